FILE: rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

FILE: rtl/hptc_pkg.sv
package hptc_pkg;

   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 48;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TEMP    = 3'd0,
      CSR_PRESS_A = 3'd1,
      CSR_PRESS_B = 3'd2,
      CSR_PRESS_C = 3'd3,
      CSR_HUM_A   = 3'd4,
      CSR_HUM_B   = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [19:0] raw_pressure;
      logic [19:0] raw_temperature;
      logic [15:0] raw_humidity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature;
      logic [31:0]        pressure;
      logic [16:0]        humidity;
   } rsp_type;

   typedef struct packed {
      logic [47:0] temp;
      logic [47:0] press_a;
      logic [47:0] press_b;
      logic [47:0] press_c;
      logic [31:0] hum_a;
      logic [39:0] hum_b;
   } coeff_type;

   localparam int unsigned DivSteps = 32;

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      asr = 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] v);
      sx16 = {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx8(input logic [7:0] v);
      sx8 = {{24{v[7]}}, v};
   endfunction

endpackage

FILE: rtl/humidity_pressure_temp_compensation.sv
// Throughput: one transfer per cycle when not stalled; the 32-stage divider pipeline sets the depth.
// The whole pipeline freezes while the output register holds an untaken result.
// Reset: synchronous, active high; clears valid bits and all coefficient registers.
`include "assert_macros.svh"
module humidity_pressure_temp_compensation (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  hptc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output hptc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [hptc_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [hptc_pkg::CsrDataWidth-1:0]    csr_wr_data
);
   hptc_pkg::coeff_type coeff_ff;
   logic advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            hptc_pkg::CSR_TEMP:    coeff_ff.temp    <= csr_wr_data;
            hptc_pkg::CSR_PRESS_A: coeff_ff.press_a <= csr_wr_data;
            hptc_pkg::CSR_PRESS_B: coeff_ff.press_b <= csr_wr_data;
            hptc_pkg::CSR_PRESS_C: coeff_ff.press_c <= csr_wr_data;
            hptc_pkg::CSR_HUM_A:   coeff_ff.hum_a   <= csr_wr_data[31:0];
            hptc_pkg::CSR_HUM_B:   coeff_ff.hum_b   <= csr_wr_data[39:0];
            default: ;
         endcase
      end
   end

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   logic        f_valid, f_double;
   logic [31:0] f_temp, f_hum, f_num, f_den;

   hptc_front u_front (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_valid && advance), .in_req(req_data), .coeff(coeff_ff),
      .out_valid(f_valid), .out_temp(f_temp), .out_hum(f_hum),
      .out_num(f_num), .out_den(f_den), .out_double(f_double)
   );

   logic        d_valid, d_double;
   logic [31:0] d_quot;
   logic [95:0] d_side;

   hptc_divider u_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(f_valid), .in_num(f_num), .in_den(f_den), .in_double(f_double),
      .in_side({f_temp, f_hum, 31'd0, (f_den == 32'd0)}),
      .out_valid(d_valid), .out_quot(d_quot), .out_double(d_double), .out_side(d_side)
   );

   hptc_back u_back (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(d_valid), .in_quot(d_quot), .in_double(d_double),
      .in_zero(d_side[0] | (|d_side[31:1])), .in_temp(d_side[95:64]),
      .in_hum(d_side[48:32]), .coeff(coeff_ff),
      .out_valid(rsp_valid), .out_rsp(rsp_data)
   );

   `ASSERT_IMPL(a_stall_holds, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `ASSERT_IMPL(a_stall_data, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_data))
   `ASSERT_IMPL(a_hum_range, clock, reset, rsp_valid |-> rsp_data.humidity <= 17'd102400)
endmodule

FILE: rtl/hptc_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
module hptc_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  logic [31:0] in_num,
   input  logic [31:0] in_den,
   input  logic        in_double,
   input  logic [95:0] in_side,
   output logic        out_valid,
   output logic [31:0] out_quot,
   output logic        out_double,
   output logic [95:0] out_side
);
   localparam int unsigned N = hptc_pkg::DivSteps;

   logic [N:0]       vld_ff;
   logic [31:0]      num_ff  [N+1];
   logic [31:0]      rem_ff  [N+1];
   logic [31:0]      den_ff  [N+1];
   logic [N:0]       dbl_ff;
   logic [95:0]      side_ff [N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[N-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff[0]  <= in_num;
         rem_ff[0]  <= '0;
         den_ff[0]  <= in_den;
         dbl_ff[0]  <= in_double;
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 0; s < N; s++) begin : g_step
      logic [32:0] trial_in;
      logic [32:0] diff_in;
      assign trial_in = {rem_ff[s], num_ff[s][31]};
      assign diff_in  = trial_in - {1'b0, den_ff[s]};
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!diff_in[32]) begin
               rem_ff[s+1] <= diff_in[31:0];
               num_ff[s+1] <= {num_ff[s][30:0], 1'b1};
            end else begin
               rem_ff[s+1] <= trial_in[31:0];
               num_ff[s+1] <= {num_ff[s][30:0], 1'b0};
            end
            den_ff[s+1]  <= den_ff[s];
            dbl_ff[s+1]  <= dbl_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid  = vld_ff[N];
   assign out_quot   = num_ff[N];
   assign out_double = dbl_ff[N];
   assign out_side   = side_ff[N];
endmodule

FILE: rtl/hptc_front.sv
// Temperature, pressure setup and humidity, ahead of the divider.
module hptc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  hptc_pkg::req_type   in_req,
   input  hptc_pkg::coeff_type coeff,
   output logic                out_valid,
   output logic [31:0]         out_temp,
   output logic [31:0]         out_hum,
   output logic [31:0]         out_num,
   output logic [31:0]         out_den,
   output logic                out_double
);
   localparam int unsigned D = 9;

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, h1, h2, h3, h4, h5, h6;
   logic [D-1:0] vld_ff;

   assign t1 = {16'd0, coeff.temp[15:0]};
   assign t2 = hptc_pkg::sx16(coeff.temp[31:16]);
   assign t3 = hptc_pkg::sx16(coeff.temp[47:32]);
   assign p1 = {16'd0, coeff.press_a[15:0]};
   assign p2 = hptc_pkg::sx16(coeff.press_a[31:16]);
   assign p3 = hptc_pkg::sx16(coeff.press_a[47:32]);
   assign p4 = hptc_pkg::sx16(coeff.press_b[15:0]);
   assign p5 = hptc_pkg::sx16(coeff.press_b[31:16]);
   assign p6 = hptc_pkg::sx16(coeff.press_b[47:32]);
   assign h1 = {24'd0, coeff.hum_a[7:0]};
   assign h2 = hptc_pkg::sx16(coeff.hum_a[23:8]);
   assign h3 = {24'd0, coeff.hum_a[31:24]};
   assign h4 = hptc_pkg::sx16(coeff.hum_b[15:0]);
   assign h5 = hptc_pkg::sx16(coeff.hum_b[31:16]);
   assign h6 = hptc_pkg::sx8(coeff.hum_b[39:32]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[D-2:0], in_valid};
      end
   end
   assign out_valid = vld_ff[D-1];

   // stage 1: temperature products
   logic [19:0] adcp1_ff, adcp2_ff, adcp3_ff, adcp4_ff, adcp5_ff, adcp6_ff;
   logic [15:0] adch1_ff, adch2_ff, adch3_ff, adch4_ff;
   logic [31:0] ta_in, tb_in, tv1_ff, bb_ff;
   assign ta_in = hptc_pkg::asr({12'd0, in_req.raw_temperature}, 3) - (t1 << 1);
   assign tb_in = hptc_pkg::asr({12'd0, in_req.raw_temperature}, 4) - t1;

   // stage 2: t3 product
   logic [31:0] tv1b_ff, tv2_ff;
   // stage 3: tfine
   logic [31:0] tfine_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         tv1_ff   <= hptc_pkg::asr(32'(ta_in * t2), 11);
         bb_ff    <= 32'(tb_in * tb_in);
         adcp1_ff <= in_req.raw_pressure;
         adch1_ff <= in_req.raw_humidity;
         tv1b_ff  <= tv1_ff;
         tv2_ff   <= hptc_pkg::asr(32'(hptc_pkg::asr(bb_ff, 12) * t3), 14);
         adcp2_ff <= adcp1_ff;
         adch2_ff <= adch1_ff;
         tfine_ff <= tv1b_ff + tv2_ff;
         adcp3_ff <= adcp2_ff;
         adch3_ff <= adch2_ff;
      end
   end

   // stage 4: first products of pressure and humidity
   logic [31:0] pv1_in, pq_in, hx_in;
   logic [31:0] temp4_ff, qq_ff, pv1p5_ff, p2v1_ff;
   logic [31:0] h5x_ff, xh6_ff, xh3_ff;
   assign pv1_in = hptc_pkg::asr(tfine_ff, 1) - 32'd64000;
   assign pq_in  = hptc_pkg::asr(pv1_in, 2);
   assign hx_in  = tfine_ff - 32'd76800;
   always_ff @(posedge clock) begin
      if (advance) begin
         temp4_ff <= hptc_pkg::asr(32'(tfine_ff * 32'd5) + 32'd128, 8);
         qq_ff    <= 32'(pq_in * pq_in);
         pv1p5_ff <= 32'(pv1_in * p5);
         p2v1_ff  <= 32'(p2 * pv1_in);
         h5x_ff   <= 32'(h5 * hx_in);
         xh6_ff   <= 32'(hx_in * h6);
         xh3_ff   <= 32'(hx_in * h3);
         adcp4_ff <= adcp3_ff;
         adch4_ff <= adch3_ff;
      end
   end

   // stage 5
   logic [31:0] temp5_ff, pv2a_ff, p3qq_ff, p2v1b_ff, left_ff, inner5_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         temp5_ff  <= temp4_ff;
         pv2a_ff   <= 32'(hptc_pkg::asr(qq_ff, 11) * p6) + (pv1p5_ff << 1);
         p3qq_ff   <= 32'(p3 * hptc_pkg::asr(qq_ff, 13));
         p2v1b_ff  <= p2v1_ff;
         left_ff   <= hptc_pkg::asr(({16'd0, adch4_ff} << 14) - (h4 << 20) - h5x_ff
                                    + 32'd16384, 15);
         inner5_ff <= 32'(hptc_pkg::asr(xh6_ff, 10)
                          * (hptc_pkg::asr(xh3_ff, 11) + 32'd32768));
         adcp5_ff  <= adcp4_ff;
      end
   end

   // stage 6
   logic [31:0] temp6_ff, pv2b_ff, pv1c_ff, left6_ff, inner6_ff;
   logic [31:0] pv1s_in, inn_in;
   assign pv1s_in = hptc_pkg::asr(hptc_pkg::asr(p3qq_ff, 3) + hptc_pkg::asr(p2v1b_ff, 1), 18);
   assign inn_in  = hptc_pkg::asr(inner5_ff, 10) + 32'd2097152;
   always_ff @(posedge clock) begin
      if (advance) begin
         temp6_ff  <= temp5_ff;
         pv2b_ff   <= hptc_pkg::asr(pv2a_ff, 2) + (p4 << 16);
         pv1c_ff   <= 32'((32'd32768 + pv1s_in) * p1);
         left6_ff  <= left_ff;
         inner6_ff <= 32'(inn_in * h2);
         adcp6_ff  <= adcp5_ff;
      end
   end

   // stage 7
   logic [31:0] temp7_ff, den7_ff, pn7_ff, hxx_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         temp7_ff <= temp6_ff;
         den7_ff  <= hptc_pkg::asr(pv1c_ff, 15);
         pn7_ff   <= (32'd1048576 - {12'd0, adcp6_ff}) - hptc_pkg::asr(pv2b_ff, 12);
         hxx_ff   <= 32'(left6_ff * hptc_pkg::asr(inner6_ff + 32'd8192, 14));
      end
   end

   // stage 8
   logic [31:0] temp8_ff, den8_ff, pn8_ff, hx8_ff, asq8_ff, aa_in;
   assign aa_in = hptc_pkg::asr(hxx_ff, 15);
   always_ff @(posedge clock) begin
      if (advance) begin
         temp8_ff <= temp7_ff;
         den8_ff  <= den7_ff;
         pn8_ff   <= 32'(pn7_ff * 32'd3125);
         hx8_ff   <= hxx_ff;
         asq8_ff  <= hptc_pkg::asr(32'(aa_in * aa_in), 7);
      end
   end

   // stage 9
   logic [31:0] hsub_in, hfin_in;
   logic [31:0] temp9_ff, den9_ff, num9_ff, hum9_ff;
   logic        dbl9_ff;
   assign hsub_in = hx8_ff - hptc_pkg::asr(32'(asq8_ff * h1), 4);
   always_comb begin
      hfin_in = hsub_in;
      if (hfin_in[31]) begin
         hfin_in = '0;
      end
      if (hfin_in > 32'd419430400) begin
         hfin_in = 32'd419430400;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         temp9_ff <= temp8_ff;
         den9_ff  <= den8_ff;
         dbl9_ff  <= pn8_ff[31];
         num9_ff  <= pn8_ff[31] ? pn8_ff : (pn8_ff << 1);
         hum9_ff  <= hfin_in >> 12;
      end
   end

   assign out_temp   = temp9_ff;
   assign out_hum    = hum9_ff;
   assign out_num    = num9_ff;
   assign out_den    = den9_ff;
   assign out_double = dbl9_ff;
endmodule

FILE: rtl/hptc_back.sv
// Pressure correction after the divider.
module hptc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [31:0]         in_quot,
   input  logic                in_double,
   input  logic                in_zero,
   input  logic [31:0]         in_temp,
   input  logic [16:0]         in_hum,
   input  hptc_pkg::coeff_type coeff,
   output logic                out_valid,
   output hptc_pkg::rsp_type   out_rsp
);
   logic [31:0] p7, p8, p9, p_in;
   logic [2:0]  vld_ff;
   assign p7 = hptc_pkg::sx16(coeff.press_c[15:0]);
   assign p8 = hptc_pkg::sx16(coeff.press_c[31:16]);
   assign p9 = hptc_pkg::sx16(coeff.press_c[47:32]);
   assign p_in = in_double ? (in_quot << 1) : in_quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   logic [31:0] p1_ff, sq_ff, b1_ff, t1_ff, t2_ff, p2_ff, a2_ff, b2_ff;
   logic [16:0] h1_ff, h2_ff;
   logic        z1_ff, z2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ff <= p_in;
         sq_ff <= 32'((p_in >> 3) * (p_in >> 3)) >> 13;
         b1_ff <= hptc_pkg::asr(32'((p_in >> 2) * p8), 13);
         z1_ff <= in_zero;
         t1_ff <= in_temp;
         h1_ff <= in_hum;
         p2_ff <= p1_ff;
         a2_ff <= hptc_pkg::asr(32'(p9 * sq_ff), 12);
         b2_ff <= b1_ff;
         z2_ff <= z1_ff;
         t2_ff <= t1_ff;
         h2_ff <= h1_ff;
         out_rsp.temperature <= t2_ff;
         out_rsp.humidity    <= h2_ff;
         out_rsp.pressure    <= z2_ff ? 32'd0
                                : p2_ff + hptc_pkg::asr(a2_ff + b2_ff + p7, 4);
      end
   end
   assign out_valid = vld_ff[2];
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   hptc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   hptc_pkg::rsp_type rsp_data;
   logic csr_wr_en = 0;
   logic [hptc_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [hptc_pkg::CsrDataWidth-1:0] csr_wr_data = '0;

   humidity_pressure_temp_compensation dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   logic [47:0] k_temp, k_pa, k_pb, k_pc;
   logic [31:0] k_ha;
   logic [39:0] k_hb;

   hptc_pkg::req_type pending_reqs[$];
   hptc_pkg::rsp_type expected_rsps[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   function automatic logic [31:0] sra(input logic [31:0] x, input int n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] s16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic hptc_pkg::rsp_type compensate(input hptc_pkg::req_type r);
      logic [31:0] adc_p, adc_t, adc_h;
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      logic [31:0] a, b, v1, v2, q, qq, p, tfine, x, left, inner;
      hptc_pkg::rsp_type o;
      adc_p = {12'd0, r.raw_pressure};
      adc_t = {12'd0, r.raw_temperature};
      adc_h = {16'd0, r.raw_humidity};
      t1 = {16'd0, k_temp[15:0]}; t2 = s16(k_temp[31:16]); t3 = s16(k_temp[47:32]);
      p1 = {16'd0, k_pa[15:0]}; p2 = s16(k_pa[31:16]); p3 = s16(k_pa[47:32]);
      p4 = s16(k_pb[15:0]); p5 = s16(k_pb[31:16]); p6 = s16(k_pb[47:32]);
      p7 = s16(k_pc[15:0]); p8 = s16(k_pc[31:16]); p9 = s16(k_pc[47:32]);
      h1 = {24'd0, k_ha[7:0]}; h2 = s16(k_ha[23:8]); h3 = {24'd0, k_ha[31:24]};
      h4 = s16(k_hb[15:0]); h5 = s16(k_hb[31:16]); h6 = {{24{k_hb[39]}}, k_hb[39:32]};
      a = sra(adc_t, 3) - (t1 << 1);
      v1 = sra(a * t2, 11);
      b = sra(adc_t, 4) - t1;
      v2 = sra(sra(b * b, 12) * t3, 14);
      tfine = v1 + v2;
      o.temperature = sra(tfine * 32'd5 + 32'd128, 8);
      v1 = sra(tfine, 1) - 32'd64000;
      q = sra(v1, 2);
      qq = q * q;
      v2 = sra(qq, 11) * p6;
      v2 = v2 + ((v1 * p5) << 1);
      v2 = sra(v2, 2) + (p4 << 16);
      v1 = sra(sra(p3 * sra(qq, 13), 3) + sra(p2 * v1, 1), 18);
      v1 = sra((32'd32768 + v1) * p1, 15);
      if (v1 == 0) begin
         p = 0;
      end else begin
         p = ((32'd1048576 - adc_p) - sra(v2, 12)) * 32'd3125;
         if (p < 32'h8000_0000) p = (p << 1) / v1;
         else p = (p / v1) * 32'd2;
         a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
         b = sra((p >> 2) * p8, 13);
         p = p + sra(a + b + p7, 4);
      end
      o.pressure = p;
      x = tfine - 32'd76800;
      left = sra((adc_h << 14) - (h4 << 20) - (h5 * x) + 32'd16384, 15);
      inner = sra(x * h6, 10) * (sra(x * h3, 11) + 32'd32768);
      inner = sra(inner, 10) + 32'd2097152;
      inner = sra(inner * h2 + 32'd8192, 14);
      x = left * inner;
      a = sra(x, 15);
      x = x - sra(sra(a * a, 7) * h1, 4);
      if (x[31]) x = 0;
      if (x > 32'd419430400) x = 32'd419430400;
      o.humidity = 17'(x >> 12);
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_rsps.push_back(compensate(req_data));
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1;
            req_data <= pending_reqs.pop_front();
         end else begin
            req_valid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected transfer %h", rsp_data);
               errors++;
            end else begin
               hptc_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (e.temperature !== rsp_data.temperature) begin
                  $error("temperature exp %0d got %0d", e.temperature, rsp_data.temperature);
                  errors++;
               end
               if (e.pressure !== rsp_data.pressure) begin
                  $error("pressure exp %0d got %0d", e.pressure, rsp_data.pressure);
                  errors++;
               end
               if (e.humidity !== rsp_data.humidity) begin
                  $error("humidity exp %0d got %0d", e.humidity, rsp_data.humidity);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(input hptc_pkg::csr_idx_type idx, input logic [47:0] val);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      case (idx)
         hptc_pkg::CSR_TEMP:    k_temp = val;
         hptc_pkg::CSR_PRESS_A: k_pa = val;
         hptc_pkg::CSR_PRESS_B: k_pb = val;
         hptc_pkg::CSR_PRESS_C: k_pc = val;
         hptc_pkg::CSR_HUM_A:   k_ha = val[31:0];
         hptc_pkg::CSR_HUM_B:   k_hb = val[39:0];
         default: ;
      endcase
   endtask

   task automatic out_of_range_write();
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= 3'd7;
      csr_wr_data <= 48'({$urandom, $urandom});
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom), $urandom};
   endfunction

   task automatic typical_coeffs();
      csr_write(hptc_pkg::CSR_TEMP, {16'd50, 16'd26435, 16'd27504});
      csr_write(hptc_pkg::CSR_PRESS_A, {16'hF3F6, 16'hD6D0, 16'd36477});
      csr_write(hptc_pkg::CSR_PRESS_B, {16'hFFF9, 16'd140, 16'd2855});
      csr_write(hptc_pkg::CSR_PRESS_C, {16'd6000, 16'hD8A0, 16'd15});
      csr_write(hptc_pkg::CSR_HUM_A, {8'd0, 16'd359, 8'd75});
      csr_write(hptc_pkg::CSR_HUM_B, {8'd30, 16'd50, 16'd300});
   endtask

   task automatic random_coeffs();
      csr_write(hptc_pkg::CSR_TEMP, rand48());
      csr_write(hptc_pkg::CSR_PRESS_A, rand48());
      csr_write(hptc_pkg::CSR_PRESS_B, rand48());
      csr_write(hptc_pkg::CSR_PRESS_C, rand48());
      csr_write(hptc_pkg::CSR_HUM_A, rand48());
      csr_write(hptc_pkg::CSR_HUM_B, rand48());
   endtask

   task automatic add_random(input int n, input bit typical);
      hptc_pkg::req_type r;
      repeat (n) begin
         if (typical) begin
            r.raw_temperature = 20'($urandom_range(540000, 400000));
            r.raw_pressure = 20'($urandom_range(450000, 250000));
            r.raw_humidity = 16'($urandom_range(40000, 15000));
         end else begin
            r = hptc_pkg::req_type'(56'({$urandom, $urandom}));
         end
         pending_reqs.push_back(r);
      end
   endtask

   task automatic add_directed();
      hptc_pkg::req_type r;
      pending_reqs.push_back('0);
      pending_reqs.push_back('1);
      r.raw_pressure = 20'hFFFFF; r.raw_temperature = 0; r.raw_humidity = 16'hFFFF;
      pending_reqs.push_back(r);
      r.raw_pressure = 0; r.raw_temperature = 20'hFFFFF; r.raw_humidity = 0;
      pending_reqs.push_back(r);
      r.raw_pressure = 20'd415148; r.raw_temperature = 20'd519888; r.raw_humidity = 16'd27000;
      pending_reqs.push_back(r);
      r.raw_pressure = 20'h80000; r.raw_temperature = 20'h80000; r.raw_humidity = 16'h8000;
      pending_reqs.push_back(r);
   endtask

   initial begin
      k_temp = 0; k_pa = 0; k_pb = 0; k_pc = 0; k_ha = 0; k_hb = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      // all-zero coefficients: zero divisor
      add_directed();
      drain();
      typical_coeffs();
      out_of_range_write();
      add_directed();
      add_random(10, 1);
      drain();
      csr_write(hptc_pkg::CSR_TEMP, '1);
      csr_write(hptc_pkg::CSR_PRESS_A, '1);
      csr_write(hptc_pkg::CSR_PRESS_B, '1);
      csr_write(hptc_pkg::CSR_PRESS_C, '1);
      csr_write(hptc_pkg::CSR_HUM_A, '1);
      csr_write(hptc_pkg::CSR_HUM_B, '1);
      add_directed();
      drain();
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 80 : 0;
         recv_stall_pct = (ph == 0) ? 80 : (ph == 1) ? 22 : 0;
         typical_coeffs();
         add_random(200, 1);
         add_random(40, 0);
         drain();
         random_coeffs();
         add_random(90, 0);
         drain();
      end
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_top: errors");
      $finish;
   end
endmodule
